// ===== design/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
`default_nettype none
package rrts_pkg;
    typedef enum logic [2:0] {
        ST_FREE    = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_DEAD    = 3'd4
    } slot_state_t;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_YIELD  = 3'd2;
    localparam logic [2:0] OP_KILL   = 3'd3;
    localparam logic [2:0] OP_SIGNAL = 3'd4;

    localparam logic [4:0] SIG_KILL = 5'd9;
    localparam logic [4:0] SIG_CONT = 5'd18;
    localparam logic [4:0] SIG_STOP = 5'd19;

    localparam logic [0:0] CFG_TIME_SLICE = 1'd0;
    localparam logic [0:0] CFG_ENABLED    = 1'd1;
endpackage
`default_nettype wire

// ===== design/round_robin_task_scheduler_unit.sv =====
// Round-robin time-slice task scheduler, top level.
// Rejected requests, and a tick or yield with nothing to do, go straight to the result;
// a create scans for the lowest free slot, writes it, and links it in after the head.
// Ring walks (lookup, reap, pick) read one entry at a time; the worst case is a kill of the
// running task found last. One request at a time, the next one accepted in the cycle
// after the result is taken. Reset frees all slots, clears control state.
`default_nettype none
module round_robin_task_scheduler_unit #(
    parameter int TASK_SLOTS   = 16,
    parameter int SIGNAL_COUNT = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [15:0] target_pid,
    input  wire logic [4:0]  signal_number,
    input  wire logic        handler_ignores,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [15:0]      result_pid,
    output logic             switched,
    output logic [15:0]      running_pid,
    output logic             running_valid
);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int PW = SIGNAL_COUNT;

    typedef enum logic [4:0] {
        S_IDLE, S_FREE_SCAN, S_CREATE_RD, S_CREATE_WR, S_CREATE_LINK,
        S_FIND_RD, S_FIND_CHK, S_SIG_ACT,
        S_TICK_RD, S_TICK_CHK,
        S_REAP_RD, S_REAP_CHK, S_REAP_END,
        S_PICK_START, S_PICK_RD, S_PICK_CHK, S_PICK_NEXT,
        S_SWITCH, S_SWPID,
        S_DONE
    } fsm_t;

    // slot states live in flops (reset to free); payload in memories
    rrts_pkg::slot_state_t state_reg [TASK_SLOTS];
    logic [15:0]   pid_mem   [TASK_SLOTS];
    logic [SW-1:0] next_mem  [TASK_SLOTS];
    logic [15:0]   slice_mem [TASK_SLOTS];
    logic [PW-1:0] pend_mem  [TASK_SLOTS];

    logic [15:0]   pid_rd_reg, slice_rd_reg;
    logic [SW-1:0] next_rd_reg;
    logic [PW-1:0] pend_rd_reg;

    fsm_t          fsm_reg;
    logic [15:0]   time_slice_reg;
    logic          enabled_reg;
    logic [SW-1:0] head_reg, run_reg;
    logic          nonempty_reg;
    logic [15:0]   pid_cnt_reg;
    logic [CW-1:0] live_reg;
    logic [15:0]   run_pid_reg;

    logic [2:0]    op_reg;
    logic [15:0]   tpid_reg;
    logic [4:0]    sig_reg;
    logic          ign_reg;

    logic [SW-1:0] cur_reg, new_reg, last_kept_reg, first_kept_reg, start_reg;
    logic          any_kept_reg;
    logic [CW-1:0] cnt_reg;
    logic          st_reg, sw_reg;
    logic [15:0]   rpid_reg;

    // memory port control (single read address, single write per memory)
    logic [SW-1:0] rd_addr;
    logic          rd_en;
    logic          pid_we, next_we, slice_we, pend_we;
    logic [SW-1:0] pid_wa, next_wa, slice_wa, pend_wa;
    logic [15:0]   pid_wd, slice_wd;
    logic [SW-1:0] next_wd;
    logic [PW-1:0] pend_wd;

    logic          table_full;
    logic          sig_bad;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pid_rd_reg   <= pid_mem[rd_addr];
            next_rd_reg  <= next_mem[rd_addr];
            slice_rd_reg <= slice_mem[rd_addr];
            pend_rd_reg  <= pend_mem[rd_addr];
        end
        if (pid_we) pid_mem[pid_wa] <= pid_wd;
        if (slice_we) slice_mem[slice_wa] <= slice_wd;
        if (pend_we) pend_mem[pend_wa] <= pend_wd;
        if (next_we) next_mem[next_wa] <= next_wd;
    end

    function automatic logic runnable(rrts_pkg::slot_state_t s);
        return (s == rrts_pkg::ST_READY) || (s == rrts_pkg::ST_RUNNING);
    endfunction

    assign in_ready      = (fsm_reg == S_IDLE);
    assign out_valid     = (fsm_reg == S_DONE);
    assign status        = st_reg;
    assign result_pid    = rpid_reg;
    assign switched      = sw_reg;
    assign running_pid   = nonempty_reg ? run_pid_reg : 16'd0;
    assign running_valid = nonempty_reg;

    assign table_full = (live_reg >= CW'(TASK_SLOTS));
    assign sig_bad    = (operation == rrts_pkg::OP_SIGNAL)
                        && ((signal_number == 5'd0) || (int'(signal_number) >= SIGNAL_COUNT));

    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = cur_reg;
        pid_we   = 1'b0;
        pid_wa   = new_reg;
        pid_wd   = pid_cnt_reg;
        slice_we = 1'b0;
        slice_wa = new_reg;
        slice_wd = time_slice_reg;
        pend_we  = 1'b0;
        pend_wa  = new_reg;
        pend_wd  = '0;
        next_we  = 1'b0;
        next_wa  = new_reg;
        next_wd  = new_reg;
        case (fsm_reg)
            S_CREATE_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
            end
            S_CREATE_WR:
            begin
                pid_we   = 1'b1;
                slice_we = 1'b1;
                pend_we  = 1'b1;
                next_we  = 1'b1;
                // insert after head: new slot takes the head's old successor
                if (nonempty_reg)
                    next_wd = next_rd_reg;
            end
            S_CREATE_LINK:
            begin
                next_we = 1'b1;
                next_wa = head_reg;
                next_wd = new_reg;
            end
            S_FIND_RD, S_REAP_RD, S_PICK_CHK:
                rd_en = 1'b1;
            S_TICK_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = run_reg;
            end
            S_TICK_CHK:
            begin
                slice_we = 1'b1;
                slice_wa = run_reg;
                slice_wd = (slice_rd_reg != 16'd0) ? slice_rd_reg - 16'd1 : 16'd0;
            end
            S_SIG_ACT:
            begin
                pend_wa = cur_reg;
                pend_wd = pend_rd_reg | (PW'(1) << sig_reg);
                pend_we = (op_reg == rrts_pkg::OP_SIGNAL)
                          && (sig_reg != rrts_pkg::SIG_KILL)
                          && (sig_reg != rrts_pkg::SIG_STOP)
                          && (sig_reg != rrts_pkg::SIG_CONT)
                          && !ign_reg;
            end
            S_REAP_CHK:
            begin
                // relink previous kept slot to this one
                if (!(state_reg[cur_reg] == rrts_pkg::ST_DEAD && cur_reg != run_reg)
                    && any_kept_reg)
                begin
                    next_we = 1'b1;
                    next_wa = last_kept_reg;
                    next_wd = cur_reg;
                end
            end
            S_REAP_END:
            begin
                if (any_kept_reg)
                begin
                    next_we = 1'b1;
                    next_wa = last_kept_reg;
                    next_wd = first_kept_reg;
                end
            end
            S_PICK_START:
            begin
                rd_en   = 1'b1;
                rd_addr = run_reg;
            end
            S_SWITCH:
            begin
                slice_we = 1'b1;
                slice_wa = run_reg;
                rd_en    = 1'b1;
            end
            S_SWPID:
            begin
                slice_we = 1'b1;
                slice_wa = cur_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_IDLE;
            time_slice_reg <= 16'd10;
            enabled_reg    <= 1'b0;
            head_reg       <= '0;
            run_reg        <= '0;
            nonempty_reg   <= 1'b0;
            pid_cnt_reg    <= '0;
            live_reg       <= '0;
            run_pid_reg    <= '0;
            op_reg         <= '0;
            tpid_reg       <= '0;
            sig_reg        <= '0;
            ign_reg        <= 1'b0;
            cur_reg        <= '0;
            new_reg        <= '0;
            last_kept_reg  <= '0;
            first_kept_reg <= '0;
            start_reg      <= '0;
            any_kept_reg   <= 1'b0;
            cnt_reg        <= '0;
            st_reg         <= 1'b0;
            sw_reg         <= 1'b0;
            rpid_reg       <= '0;
            for (int i = 0; i < TASK_SLOTS; i++) state_reg[i] <= rrts_pkg::ST_FREE;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rrts_pkg::CFG_TIME_SLICE) time_slice_reg <= cfg_data;
                else if (cfg_index == rrts_pkg::CFG_ENABLED) enabled_reg <= cfg_data[0];
            end
            case (fsm_reg)
                S_IDLE:
                if (in_valid)
                begin
                    op_reg       <= operation;
                    tpid_reg     <= target_pid;
                    sig_reg      <= signal_number;
                    ign_reg      <= handler_ignores;
                    sw_reg       <= 1'b0;
                    rpid_reg     <= '0;
                    cnt_reg      <= '0;
                    any_kept_reg <= 1'b0;
                    cur_reg      <= (operation == rrts_pkg::OP_CREATE) ? '0 : head_reg;
                    case (operation)
                        rrts_pkg::OP_CREATE:
                        begin
                            st_reg  <= table_full;
                            fsm_reg <= table_full ? S_DONE : S_FREE_SCAN;
                        end
                        rrts_pkg::OP_TICK:
                        begin
                            st_reg  <= 1'b0;
                            fsm_reg <= (enabled_reg && nonempty_reg) ? S_TICK_RD : S_DONE;
                        end
                        rrts_pkg::OP_YIELD:
                        begin
                            st_reg  <= 1'b0;
                            fsm_reg <= (enabled_reg && nonempty_reg) ? S_REAP_RD : S_DONE;
                        end
                        rrts_pkg::OP_KILL, rrts_pkg::OP_SIGNAL:
                        begin
                            st_reg  <= sig_bad || !nonempty_reg;
                            fsm_reg <= (sig_bad || !nonempty_reg) ? S_DONE : S_FIND_RD;
                        end
                        default:
                        begin
                            st_reg  <= 1'b1;
                            fsm_reg <= S_DONE;
                        end
                    endcase
                end
                S_FREE_SCAN:
                begin
                    if (state_reg[cur_reg] == rrts_pkg::ST_FREE)
                    begin
                        new_reg <= cur_reg;
                        fsm_reg <= S_CREATE_RD;
                    end
                    else if (cur_reg == SW'(TASK_SLOTS - 1))
                    begin
                        st_reg  <= 1'b1;
                        fsm_reg <= S_DONE;
                    end
                    else cur_reg <= cur_reg + SW'(1);
                end
                S_CREATE_RD: fsm_reg <= S_CREATE_WR;
                S_CREATE_WR:
                begin
                    rpid_reg    <= pid_cnt_reg;
                    pid_cnt_reg <= pid_cnt_reg + 16'd1;
                    live_reg    <= live_reg + CW'(1);
                    if (!nonempty_reg)
                    begin
                        state_reg[new_reg] <= rrts_pkg::ST_RUNNING;
                        head_reg     <= new_reg;
                        run_reg      <= new_reg;
                        run_pid_reg  <= pid_cnt_reg;
                        nonempty_reg <= 1'b1;
                        fsm_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg[new_reg] <= rrts_pkg::ST_READY;
                        fsm_reg <= S_CREATE_LINK;
                    end
                end
                S_CREATE_LINK: fsm_reg <= S_DONE;
                S_FIND_RD: fsm_reg <= S_FIND_CHK;
                S_FIND_CHK:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (pid_rd_reg == tpid_reg)
                    begin
                        if (state_reg[cur_reg] == rrts_pkg::ST_DEAD)
                        begin
                            st_reg  <= 1'b1;
                            fsm_reg <= S_DONE;
                        end
                        else fsm_reg <= S_SIG_ACT;
                    end
                    else if (next_rd_reg == head_reg || cnt_reg == CW'(TASK_SLOTS - 1))
                    begin
                        st_reg  <= 1'b1;
                        fsm_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg <= next_rd_reg;
                        fsm_reg <= S_FIND_RD;
                    end
                end
                S_SIG_ACT:
                begin
                    if (op_reg == rrts_pkg::OP_KILL || sig_reg == rrts_pkg::SIG_KILL)
                    begin
                        state_reg[cur_reg] <= rrts_pkg::ST_DEAD;
                        if (cur_reg == run_reg && enabled_reg)
                        begin
                            cur_reg <= head_reg;
                            cnt_reg <= '0;
                            fsm_reg <= S_REAP_RD;
                        end
                        else fsm_reg <= S_DONE;
                    end
                    else
                    begin
                        fsm_reg <= S_DONE;
                        if (sig_reg == rrts_pkg::SIG_STOP)
                            state_reg[cur_reg] <= rrts_pkg::ST_BLOCKED;
                        else if (sig_reg == rrts_pkg::SIG_CONT || !ign_reg)
                        begin
                            if (state_reg[cur_reg] == rrts_pkg::ST_BLOCKED)
                                state_reg[cur_reg] <= rrts_pkg::ST_READY;
                        end
                    end
                end
                S_TICK_RD: fsm_reg <= S_TICK_CHK;
                S_TICK_CHK:
                if (slice_rd_reg <= 16'd1)
                begin
                    cur_reg <= head_reg;
                    cnt_reg <= '0;
                    fsm_reg <= S_REAP_RD;
                end
                else fsm_reg <= S_DONE;
                S_REAP_RD: fsm_reg <= S_REAP_CHK;
                S_REAP_CHK:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (state_reg[cur_reg] == rrts_pkg::ST_DEAD && cur_reg != run_reg)
                    begin
                        state_reg[cur_reg] <= rrts_pkg::ST_FREE;
                        if (live_reg != '0) live_reg <= live_reg - CW'(1);
                    end
                    else
                    begin
                        if (!any_kept_reg) first_kept_reg <= cur_reg;
                        any_kept_reg  <= 1'b1;
                        last_kept_reg <= cur_reg;
                    end
                    if (next_rd_reg == head_reg || cnt_reg == CW'(TASK_SLOTS - 1))
                        fsm_reg <= S_REAP_END;
                    else
                    begin
                        cur_reg <= next_rd_reg;
                        fsm_reg <= S_REAP_RD;
                    end
                end
                S_REAP_END:
                if (!any_kept_reg)
                begin
                    nonempty_reg <= 1'b0;
                    fsm_reg      <= S_DONE;
                end
                else
                begin
                    head_reg <= first_kept_reg;
                    fsm_reg  <= S_PICK_START;
                end
                S_PICK_START: fsm_reg <= S_PICK_RD;
                S_PICK_RD:
                begin
                    // next_rd_reg holds the successor of the running slot
                    start_reg <= next_rd_reg;
                    cur_reg   <= next_rd_reg;
                    cnt_reg   <= '0;
                    fsm_reg   <= S_PICK_CHK;
                end
                S_PICK_CHK:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (runnable(state_reg[cur_reg]))
                    begin
                        if (cur_reg == run_reg) fsm_reg <= S_DONE;
                        else fsm_reg <= S_SWITCH;
                    end
                    else fsm_reg <= S_PICK_NEXT;
                end
                S_PICK_NEXT:
                if (next_rd_reg == start_reg || cnt_reg == CW'(TASK_SLOTS))
                    fsm_reg <= S_DONE;
                else
                begin
                    cur_reg <= next_rd_reg;
                    fsm_reg <= S_PICK_CHK;
                end
                S_SWITCH:
                begin
                    if (state_reg[run_reg] == rrts_pkg::ST_RUNNING)
                        state_reg[run_reg] <= rrts_pkg::ST_READY;
                    state_reg[cur_reg] <= rrts_pkg::ST_RUNNING;
                    run_reg <= cur_reg;
                    sw_reg  <= 1'b1;
                    fsm_reg <= S_SWPID;
                end
                S_SWPID:
                begin
                    run_pid_reg <= pid_rd_reg;
                    fsm_reg     <= S_DONE;
                end
                S_DONE:
                if (out_ready) fsm_reg <= S_IDLE;
                default: fsm_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== test/round_robin_task_scheduler_unit_tb.sv =====
// Self-checking testbench for the round-robin task scheduler unit.
`timescale 1ns / 1ps
module round_robin_task_scheduler_unit_tb;

    localparam int SLOTS      = 16;
    localparam int SIG_LIMIT  = 32;
    localparam int SETTLE_CYC = 4 * SLOTS + 20;

    typedef struct packed {
        logic        status;
        logic [15:0] result_pid;
        logic        switched;
        logic [15:0] running_pid;
        logic        running_valid;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [15:0] target_pid;
    logic [4:0]  signal_number;
    logic        handler_ignores;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [15:0] result_pid;
    logic        switched;
    logic [15:0] running_pid;
    logic        running_valid;

    round_robin_task_scheduler_unit #(
        .TASK_SLOTS   (SLOTS),
        .SIGNAL_COUNT (SIG_LIMIT)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .target_pid      (target_pid),
        .signal_number   (signal_number),
        .handler_ignores (handler_ignores),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .result_pid      (result_pid),
        .switched        (switched),
        .running_pid     (running_pid),
        .running_valid   (running_valid)
    );

    // scheduler shadow state
    rrts_pkg::slot_state_t task_state [SLOTS];
    logic [15:0]   task_pid [SLOTS];
    int            task_next [SLOTS];
    logic [15:0]   task_slice [SLOTS];
    logic [31:0]   task_pending [SLOTS];
    int            head_idx;
    int            run_idx;
    bit            ring_live;
    logic [15:0]   pid_seq;
    int            live_tasks;
    logic [15:0]   slice_reg;
    bit            sched_on;

    sched_result_t expected_results[$];
    int            error_count;
    bit            recv_hold;
    bit            recv_stall_mode = 1'b0;
    int            recv_mode_cnt = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int wrap_slot(int s);
        return (s >= 0 && s < SLOTS) ? s : 0;
    endfunction

    function automatic void purge_dead_slots();
        int order[SLOTS];
        int kept[SLOTS];
        int n;
        int k;
        int s;
        n = 0;
        k = 0;
        s = wrap_slot(head_idx);
        for (int i = 0; i < SLOTS; i++)
        begin
            order[n++] = s;
            s = wrap_slot(task_next[s]);
            if (s == head_idx)
                break;
        end
        for (int i = 0; i < n; i++)
        begin
            s = order[i];
            if (task_state[s] == rrts_pkg::ST_DEAD && s != run_idx)
            begin
                task_state[s] = rrts_pkg::ST_FREE;
                if (live_tasks > 0)
                    live_tasks--;
            end
            else
                kept[k++] = s;
        end
        if (k == 0)
        begin
            ring_live = 0;
            return;
        end
        for (int i = 0; i < k; i++)
            task_next[kept[i]] = kept[(i + 1) % k];
        head_idx = kept[0];
    endfunction

    function automatic bit rotate_running();
        int prev;
        int start;
        int it;
        int pick;
        if (!sched_on)
            return 0;
        purge_dead_slots();
        if (!ring_live)
            return 0;
        prev  = wrap_slot(run_idx);
        start = wrap_slot(task_next[prev]);
        it    = start;
        pick  = prev;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (task_state[it] == rrts_pkg::ST_READY || task_state[it] == rrts_pkg::ST_RUNNING)
            begin
                pick = it;
                break;
            end
            it = wrap_slot(task_next[it]);
            if (it == start)
                break;
        end
        if (pick == prev)
            return 0;
        if (task_state[prev] == rrts_pkg::ST_RUNNING)
            task_state[prev] = rrts_pkg::ST_READY;
        task_slice[prev] = slice_reg;
        task_state[pick] = rrts_pkg::ST_RUNNING;
        task_slice[pick] = slice_reg;
        run_idx = pick;
        return 1;
    endfunction

    function automatic int lookup_pid(logic [15:0] pid);
        int s;
        if (!ring_live)
            return -1;
        s = wrap_slot(head_idx);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (task_pid[s] == pid)
                return s;
            s = wrap_slot(task_next[s]);
            if (s == head_idx)
                break;
        end
        return -1;
    endfunction

    function automatic sched_result_t predict_schedule(logic [2:0] op, logic [15:0] pid,
                                                       logic [4:0] sig, logic ign);
        sched_result_t r;
        int s;
        int h;
        r = '0;
        case (op)
            rrts_pkg::OP_CREATE:
            begin
                s = -1;
                if (live_tasks < SLOTS)
                    for (int i = 0; i < SLOTS; i++)
                        if (task_state[i] == rrts_pkg::ST_FREE)
                        begin
                            s = i;
                            break;
                        end
                if (s < 0)
                    r.status = 1'b1;
                else
                begin
                    r.result_pid    = pid_seq;
                    task_pid[s]     = pid_seq;
                    pid_seq         = pid_seq + 16'd1;
                    task_state[s]   = rrts_pkg::ST_READY;
                    task_slice[s]   = slice_reg;
                    task_pending[s] = '0;
                    if (!ring_live)
                    begin
                        head_idx      = s;
                        task_next[s]  = s;
                        task_state[s] = rrts_pkg::ST_RUNNING;
                        run_idx       = s;
                        ring_live     = 1;
                    end
                    else
                    begin
                        h            = wrap_slot(head_idx);
                        task_next[s] = task_next[h];
                        task_next[h] = s;
                    end
                    live_tasks++;
                end
            end
            rrts_pkg::OP_TICK:
            begin
                if (sched_on && ring_live)
                begin
                    s = wrap_slot(run_idx);
                    if (task_slice[s] > 0)
                        task_slice[s]--;
                    if (task_slice[s] == 0)
                        r.switched = rotate_running();
                end
            end
            rrts_pkg::OP_YIELD:
                r.switched = rotate_running();
            rrts_pkg::OP_KILL, rrts_pkg::OP_SIGNAL:
            begin
                if (op == rrts_pkg::OP_SIGNAL && (sig == 0 || int'(sig) >= SIG_LIMIT))
                    r.status = 1'b1;
                else
                begin
                    s = lookup_pid(pid);
                    if (s < 0 || task_state[s] == rrts_pkg::ST_DEAD)
                        r.status = 1'b1;
                    else if (op == rrts_pkg::OP_KILL || sig == rrts_pkg::SIG_KILL)
                    begin
                        task_state[s] = rrts_pkg::ST_DEAD;
                        if (s == run_idx)
                            r.switched = rotate_running();
                    end
                    else if (sig == rrts_pkg::SIG_STOP)
                        task_state[s] = rrts_pkg::ST_BLOCKED;
                    else if (sig == rrts_pkg::SIG_CONT)
                    begin
                        if (task_state[s] == rrts_pkg::ST_BLOCKED)
                            task_state[s] = rrts_pkg::ST_READY;
                    end
                    else if (!ign)
                    begin
                        task_pending[s] |= 32'd1 << sig;
                        if (task_state[s] == rrts_pkg::ST_BLOCKED)
                            task_state[s] = rrts_pkg::ST_READY;
                    end
                end
            end
            default:
                r.status = 1'b1;
        endcase
        r.running_valid = ring_live;
        r.running_pid   = ring_live ? task_pid[wrap_slot(run_idx)] : 16'd0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ERROR %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request pending", 16'd0, 16'd0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 16'(status), 16'(want.status));
                if (result_pid !== want.result_pid)
                    report_mismatch("result_pid", result_pid, want.result_pid);
                if (switched !== want.switched)
                    report_mismatch("switched", 16'(switched), 16'(want.switched));
                if (running_pid !== want.running_pid)
                    report_mismatch("running_pid", running_pid, want.running_pid);
                if (running_valid !== want.running_valid)
                    report_mismatch("running_valid", 16'(running_valid),
                                    16'(want.running_valid));
            end
        end
    end

    // receiver: picks free-flowing or choppy stretches at random
    always @(negedge clk)
    begin
        if (recv_mode_cnt == 0)
        begin
            recv_stall_mode <= 1'($urandom_range(0, 1));
            recv_mode_cnt   <= $urandom_range(20, 120);
        end
        else
            recv_mode_cnt <= recv_mode_cnt - 1;
        out_ready <= !recv_hold && (!recv_stall_mode || ($urandom_range(0, 2) != 0));
    end

    task automatic send_request(logic [2:0] op, logic [15:0] pid, logic [4:0] sig, logic ign);
        @(negedge clk);
        operation       <= op;
        target_pid      <= pid;
        signal_number   <= sig;
        handler_ignores <= ign;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_schedule(op, pid, sig, ign));
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic wait_all_done();
        int guard;
        sender_gap(0);
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYC)
            @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic [15:0] value);
        wait_all_done();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == rrts_pkg::CFG_TIME_SLICE)
            slice_reg = value;
        else
            sched_on = value[0];
    endtask

    function automatic logic [15:0] pick_target();
        int s;
        int hops;
        if (!ring_live || $urandom_range(0, 9) == 0)
            return 16'($urandom);
        s    = wrap_slot(head_idx);
        hops = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < hops; i++)
            s = wrap_slot(task_next[s]);
        return task_pid[s];
    endfunction

    task automatic send_random_request();
        int roll;
        logic [4:0] sig;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: sig = rrts_pkg::SIG_KILL;
            1: sig = rrts_pkg::SIG_CONT;
            2, 3: sig = rrts_pkg::SIG_STOP;
            default: sig = 5'($urandom);
        endcase
        if (roll < 22)
            send_request(rrts_pkg::OP_CREATE, 16'($urandom), 5'($urandom), 1'($urandom));
        else if (roll < 50)
            send_request(rrts_pkg::OP_TICK, 16'($urandom), 5'($urandom), 1'($urandom));
        else if (roll < 65)
            send_request(rrts_pkg::OP_YIELD, 16'($urandom), 5'($urandom), 1'($urandom));
        else if (roll < 75)
            send_request(rrts_pkg::OP_KILL, pick_target(), 5'($urandom), 1'($urandom));
        else if (roll < 96)
            send_request(rrts_pkg::OP_SIGNAL, pick_target(), sig, 1'($urandom));
        else
            send_request(3'($urandom_range(5, 7)), 16'($urandom), 5'($urandom),
                         1'($urandom));
    endtask

    task automatic random_burst_run(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_random_request();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                sender_gap($urandom_range(1, 12));
        end
    endtask

    task automatic test_empty_and_errors();
        send_request(rrts_pkg::OP_TICK, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_YIELD, 16'hffff, 5'd31, 1'b1);
        send_request(rrts_pkg::OP_KILL, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_SIGNAL, 16'hffff, 5'd0, 1'b0);
        send_request(3'd5, 16'h0000, 5'd0, 1'b0);
        send_request(3'd6, 16'hffff, 5'd31, 1'b1);
        send_request(3'd7, 16'h5a5a, 5'd10, 1'b0);
    endtask

    function automatic logic [15:0] running_pid_now();
        return ring_live ? task_pid[wrap_slot(run_idx)] : 16'd0;
    endfunction

    task automatic test_lifecycle();
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'd2);
        write_register(rrts_pkg::CFG_ENABLED, 16'd1);
        send_request(rrts_pkg::OP_CREATE, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_CREATE, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_CREATE, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_TICK, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_TICK, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_SIGNAL, running_pid_now(), rrts_pkg::SIG_STOP, 1'b0);
        send_request(rrts_pkg::OP_YIELD, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_SIGNAL, 16'd0, 5'd5, 1'b1);
        send_request(rrts_pkg::OP_SIGNAL, 16'd1, 5'd31, 1'b0);
        send_request(rrts_pkg::OP_SIGNAL, 16'd0, rrts_pkg::SIG_CONT, 1'b0);
        send_request(rrts_pkg::OP_SIGNAL, 16'd2, rrts_pkg::SIG_KILL, 1'b0);
        send_request(rrts_pkg::OP_KILL, running_pid_now(), 5'd0, 1'b0);
        send_request(rrts_pkg::OP_KILL, 16'd2, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_KILL, 16'hffff, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_YIELD, 16'd0, 5'd0, 1'b0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_request(rrts_pkg::OP_CREATE, 16'd0, 5'd0, 1'b0);
    endtask

    task automatic test_zero_slice_and_disable();
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'd0);
        send_request(rrts_pkg::OP_TICK, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_YIELD, 16'd0, 5'd0, 1'b0);
        write_register(rrts_pkg::CFG_ENABLED, 16'd0);
        send_request(rrts_pkg::OP_TICK, 16'd0, 5'd0, 1'b0);
        send_request(rrts_pkg::OP_KILL, running_pid_now(), 5'd0, 1'b0);
        send_request(rrts_pkg::OP_YIELD, 16'd0, 5'd0, 1'b0);
    endtask

    task automatic test_random_phases();
        write_register(rrts_pkg::CFG_ENABLED, 16'd1);
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'd3);
        random_burst_run(260);
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'd1);
        random_burst_run(220);
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'hffff);
        random_burst_run(180);
        write_register(rrts_pkg::CFG_ENABLED, 16'd0);
        random_burst_run(80);
        write_register(rrts_pkg::CFG_ENABLED, 16'd1);
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'h5a5a & 16'h0007);
        random_burst_run(200);
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'haaaa);
        random_burst_run(60);
    endtask

    task automatic test_backpressure();
        write_register(rrts_pkg::CFG_TIME_SLICE, 16'h5555);
        fork
            begin
                recv_hold = 1'b1;
                repeat (400)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 30; i++)
            send_random_request();
        wait_all_done();
        // sender idles until everything has drained
        random_burst_run(20);
        wait_all_done();
    endtask

    initial
    begin
        error_count     = 0;
        recv_hold       = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        operation       = '0;
        target_pid      = '0;
        signal_number   = '0;
        handler_ignores = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            task_state[i]   = rrts_pkg::ST_FREE;
            task_pid[i]     = '0;
            task_next[i]    = 0;
            task_slice[i]   = '0;
            task_pending[i] = '0;
        end
        head_idx   = 0;
        run_idx    = 0;
        ring_live  = 0;
        pid_seq    = '0;
        live_tasks = 0;
        slice_reg  = 16'd10;
        sched_on   = 0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_errors();
        test_lifecycle();
        test_table_full();
        test_zero_slice_and_disable();
        test_random_phases();
        test_backpressure();
        wait_all_done();

        if (expected_results.size() != 0)
        begin
            $display("ERROR %0d results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
